[src/imaenc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package imaenc_pkg;

    localparam int ALU_W     = 19;
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 15;
    localparam int INDEX_W   = 7;
    localparam int CODE_W    = 4;
    localparam int MAG_W     = 3;
    localparam int CFG_W     = 2;
    localparam int REM_W     = 18;
    localparam int CH_LIMIT_DEFAULT = 2;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
    localparam logic signed [ALU_W:0] PRED_MAX = 20'sd32767;
    localparam logic signed [ALU_W:0] PRED_MIN = -20'sd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_MOVE,
        S_UPD
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op                 op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } t_alu_req;

    function automatic logic [STEP_W-1:0] imaenc_step(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] imaenc_adjust(input logic [MAG_W-1:0] mag);
        logic signed [4:0] d;
        case (mag)
            3'd4:    d = 5'sd2;
            3'd5:    d = 5'sd4;
            3'd6:    d = 5'sd6;
            3'd7:    d = 5'sd8;
            default: d = -5'sd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[src/imaenc_addsub.sv]
`timescale 1ns / 1ps
`default_nettype none

module imaenc_addsub
    import imaenc_pkg::*;
(
    input  wire t_alu_req               i_req,
    output logic signed [ALU_W:0]       o_res
);

    logic signed [ALU_W:0] a_ext;
    logic signed [ALU_W:0] b_ext;

    assign a_ext = (ALU_W + 1)'(i_req.a);
    assign b_ext = (ALU_W + 1)'(i_req.b);

    always_comb begin
        case (i_req.op)
            ALU_ADD: o_res = a_ext + b_ext;
            ALU_SUB: o_res = a_ext - b_ext;
            default: o_res = a_ext;
        endcase
    end

endmodule

`default_nettype wire

[src/ima_adpcm_sample_encoder.sv]
// IMA ADPCM encoder, 4 bits per sample, one or two interleaved channels.
// Input channel: i_in_valid / o_in_stall with i_sample. A request is taken
// when valid is high and stall is low; samples arrive interleaved in channel
// order. Output channel: o_out_valid / i_out_stall with o_packed_pair. One
// word goes out for every second sample: earlier code in bits 11:8, later
// code in bits 3:0.
// Each sample passes through accept, difference, three quotient bits on the
// shared add/subtract unit, step-move product, and predictor update on the
// same unit. Stall stays high until the update completes, so no new sample
// is taken while one is in work. The word is valid in the output register
// once the update of the second sample of its pair completes, in the same
// cycle the next sample can be taken; if that register is still held by a
// stalled receiver when the next word is ready, the update waits.
// i_cfg_wr_en / i_cfg_wr_data set the channel count (0 acts as 1, values
// above CH_LIMIT saturate); write it only while idle.
// Reset (synchronous, active low) clears predictors, step indices, channel
// and pairing state, drops any pending word and sets the count to 1; stall
// is held high while reset is asserted.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_sample_encoder
    import imaenc_pkg::*;
#(
    parameter int CH_LIMIT = CH_LIMIT_DEFAULT
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [CFG_W-1:0]           i_cfg_wr_data,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire  signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [SAMPLE_W-1:0]        o_packed_pair
);

    localparam int CH_W = (CH_LIMIT > 1) ? $clog2(CH_LIMIT) : 1;

    t_state                     r_state, n_state;
    logic [CFG_W-1:0]           r_channel_count, n_channel_count;
    logic [CH_W-1:0]            r_cur_ch, n_cur_ch;
    logic [CH_W-1:0]            r_ch, n_ch;
    logic signed [SAMPLE_W-1:0] r_pred [CH_LIMIT];
    logic signed [SAMPLE_W-1:0] n_pred [CH_LIMIT];
    logic [INDEX_W-1:0]         r_idx [CH_LIMIT];
    logic [INDEX_W-1:0]         n_idx [CH_LIMIT];
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SAMPLE_W-1:0] r_pred_cur, n_pred_cur;
    logic [INDEX_W-1:0]         r_idx_cur, n_idx_cur;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_neg, n_neg;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [MAG_W-1:0]           r_mag, n_mag;
    logic [1:0]                 r_bit, n_bit;
    logic [SAMPLE_W-1:0]        r_move, n_move;
    logic                       r_phase, n_phase;
    logic [CODE_W-1:0]          r_held, n_held;
    logic                       r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data, n_out_data;

    logic [3:0]                 act_count;
    logic [CH_W-1:0]            ch_sel;
    logic [3:0]                 ch_inc;
    t_alu_req                   alu_req;
    logic signed [ALU_W:0]      alu_res;
    logic [SAMPLE_W:0]          diff_abs;
    logic [REM_W-2:0]           step_sh;
    logic                       div_ge;
    logic [REM_W-1:0]           prod;
    logic [REM_W-1:0]           move_sum;
    logic signed [SAMPLE_W-1:0] pred_sat;
    logic signed [8:0]          idx_sum;
    logic [INDEX_W-1:0]         idx_new;
    logic [CODE_W-1:0]          code;
    logic                       in_accept;
    logic                       out_free;

    imaenc_addsub u_addsub (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    always_comb begin
        if (r_channel_count == '0) begin
            act_count = 4'd1;
        end else if (4'(r_channel_count) > 4'(CH_LIMIT)) begin
            act_count = 4'(CH_LIMIT);
        end else begin
            act_count = 4'(r_channel_count);
        end
    end

    assign ch_sel    = (4'(r_cur_ch) >= act_count) ? '0 : r_cur_ch;
    assign ch_inc    = 4'(r_ch) + 4'd1;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign diff_abs  = alu_res[ALU_W] ? (SAMPLE_W + 1)'(-alu_res) : (SAMPLE_W + 1)'(alu_res);
    assign step_sh   = (REM_W - 1)'(r_step) << r_bit;
    assign div_ge    = !alu_res[ALU_W];
    assign prod      = REM_W'(r_step) * REM_W'(r_mag);
    assign move_sum  = REM_W'(prod[REM_W-1:2]) + REM_W'(r_step[STEP_W-1:3]);
    assign idx_sum   = $signed({2'b00, r_idx_cur}) + 9'(imaenc_adjust(r_mag));
    assign code      = {r_neg, r_mag};

    always_comb begin
        if (alu_res > PRED_MAX) begin
            pred_sat = 16'sd32767;
        end else if (alu_res < PRED_MIN) begin
            pred_sat = -16'sd32768;
        end else begin
            pred_sat = alu_res[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        if (idx_sum < 9'sd0) begin
            idx_new = '0;
        end else if (idx_sum > $signed({2'b00, INDEX_MAX})) begin
            idx_new = INDEX_MAX;
        end else begin
            idx_new = idx_sum[INDEX_W-1:0];
        end
    end

    always_comb begin
        case (r_state)
            S_DIFF: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(r_sample);
                alu_req.b  = ALU_W'(r_pred_cur);
            end
            S_DIV: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = $signed({1'b0, r_rem});
                alu_req.b  = $signed({2'b00, step_sh});
            end
            S_UPD: begin
                alu_req.op = r_neg ? ALU_SUB : ALU_ADD;
                alu_req.a  = ALU_W'(r_pred_cur);
                alu_req.b  = $signed({3'b000, r_move});
            end
            default: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = '0;
                alu_req.b  = '0;
            end
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_channel_count = i_cfg_wr_en ? i_cfg_wr_data : r_channel_count;
        n_cur_ch        = r_cur_ch;
        n_ch            = r_ch;
        n_pred          = r_pred;
        n_idx           = r_idx;
        n_sample        = r_sample;
        n_pred_cur      = r_pred_cur;
        n_idx_cur       = r_idx_cur;
        n_step          = r_step;
        n_neg           = r_neg;
        n_rem           = r_rem;
        n_mag           = r_mag;
        n_bit           = r_bit;
        n_move          = r_move;
        n_phase         = r_phase;
        n_held          = r_held;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_data      = r_out_data;
        o_in_stall      = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                if (in_accept) begin
                    n_sample   = i_sample;
                    n_ch       = ch_sel;
                    n_pred_cur = r_pred[ch_sel];
                    n_idx_cur  = r_idx[ch_sel];
                    n_step     = imaenc_step(r_idx[ch_sel]);
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                n_neg   = alu_res[ALU_W];
                n_rem   = {diff_abs[SAMPLE_W-1:0], 2'b00};
                n_mag   = '0;
                n_bit   = 2'd2;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_ge) begin
                    n_rem = alu_res[REM_W-1:0];
                end
                n_mag = {r_mag[MAG_W-2:0], div_ge};
                n_bit = r_bit - 2'd1;
                if (r_bit == 2'd0) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                n_move  = move_sum[SAMPLE_W-1:0];
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_phase || out_free) begin
                    n_pred[r_ch] = pred_sat;
                    n_idx[r_ch]  = idx_new;
                    n_cur_ch     = (ch_inc >= act_count) ? '0 : CH_W'(ch_inc);
                    n_phase      = !r_phase;
                    if (r_phase) begin
                        n_out_valid = 1'b1;
                        n_out_data  = {4'b0000, r_held, 4'b0000, code};
                    end else begin
                        n_held = code;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CFG_W'(1);
            r_cur_ch        <= '0;
            r_phase         <= 1'b0;
            r_held          <= '0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < CH_LIMIT; i++) begin
                r_pred[i] <= '0;
                r_idx[i]  <= '0;
            end
        end else begin
            r_channel_count <= n_channel_count;
            r_cur_ch        <= n_cur_ch;
            r_phase         <= n_phase;
            r_held          <= n_held;
            r_out_valid     <= n_out_valid;
            r_pred          <= n_pred;
            r_idx           <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_sample   <= n_sample;
        r_pred_cur <= n_pred_cur;
        r_idx_cur  <= n_idx_cur;
        r_step     <= n_step;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_mag      <= n_mag;
        r_bit      <= n_bit;
        r_move     <= n_move;
        r_out_data <= n_out_data;
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_pair = r_out_data;

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIFF |-> 4'(r_ch) < act_count)
        else $error("channel select out of range");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIFF |-> r_idx_cur <= INDEX_MAX)
        else $error("step index above table");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_bit == 2'd0 |=> r_state == S_MOVE)
        else $error("quotient loop did not finish after three bits");

    a_pair_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD && r_phase && out_free |=> o_out_valid && !r_phase)
        else $error("paired word not issued");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_packed_pair[15:12] == 4'd0 && o_packed_pair[7:4] == 4'd0)
        else $error("packed word padding not zero");

endmodule

`default_nettype wire
